// ===== sv/rcl_pkg.sv =====
package rcl_pkg;

	localparam int unsigned MAX_RECORD_BYTES = 65536;
	localparam int unsigned SAT_VALUE = MAX_RECORD_BYTES + 1;
	localparam int unsigned LEN_W = $clog2(SAT_VALUE + 1);
	localparam int unsigned ACC_W = LEN_W + 2;
	localparam int unsigned COL_W = 16;
	localparam int unsigned CNT_W = 4;
	localparam int unsigned OUT_W = 17;

	localparam logic [LEN_W-1:0] SAT_LEN = LEN_W'(SAT_VALUE);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_RECORD_BYTES);
	localparam logic [COL_W-1:0] COL_MAX = '1;
	localparam logic [CNT_W-1:0] VARINT_LAST_IDX = CNT_W'(8);
	localparam logic [ACC_W-1:0] BLOB_MIN_TYPE = ACC_W'(12);

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	localparam int unsigned PADDR_W = 3;
	localparam logic REG_COLUMN_INDEX = 1'b0;

	typedef enum logic [2:0] {
		PH_SIZE  = 3'b001,
		PH_TYPES = 3'b010,
		PH_DONE  = 3'b100
	} rcl_phase_t;

	typedef struct packed {
		logic             past_size;
		logic             hit;
		logic             fail;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] header_size;
		logic [LEN_W-1:0] hit_offset;
		logic [LEN_W-1:0] hit_size;
	} rcl_summary_t;

	function automatic logic [LEN_W-1:0] sat_len(input logic [ACC_W-1:0] v, input logic big);
		logic [LEN_W-1:0] r;
		if (big || v > ACC_W'(MAX_RECORD_BYTES))
			r = SAT_LEN;
		else
			r = v[LEN_W-1:0];
		return r;
	endfunction

	function automatic logic [3:0] fixed_size(input logic [3:0] t);
		logic [3:0] r;
		case (t)
			4'd1: r = 4'd1;
			4'd2: r = 4'd2;
			4'd3: r = 4'd3;
			4'd4: r = 4'd4;
			4'd5: r = 4'd6;
			4'd6: r = 4'd8;
			4'd7: r = 4'd8;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] type_size(input logic [ACC_W-1:0] t, input logic big);
		logic [LEN_W-1:0] r;
		logic [ACC_W-1:0] d;
		d = t - BLOB_MIN_TYPE;
		if (big)
			r = SAT_LEN;
		else if (t < BLOB_MIN_TYPE)
			r = LEN_W'(fixed_size(t[3:0]));
		else
			r = sat_len({1'b0, d[ACC_W-1:1]}, 1'b0);
		return r;
	endfunction

endpackage

// ===== sv/rcl_front.sv =====
module rcl_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [7:0]               data_byte,
	input  logic                     last,
	input  logic [rcl_pkg::COL_W-1:0] column_index,
	output logic                     push,
	output rcl_pkg::rcl_summary_t    summary
);
	import rcl_pkg::*;

	rcl_phase_t       phase_q, phase_d;
	logic [ACC_W-1:0] acc_q, acc_d, acc_f;
	logic             big_q, big_d, big_f;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_f;
	logic             done_f;
	logic [LEN_W-1:0] pos_q, pos_d;
	logic [LEN_W-1:0] hdr_q, hdr_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [LEN_W-1:0] body_q, body_d;
	logic [LEN_W-1:0] hoff_q, hoff_d;
	logic [LEN_W-1:0] hsize_q, hsize_d;
	logic             hit_q, hit_d;
	logic             fail_q, fail_d;
	logic [LEN_W-1:0] sz;

	// varint byte decode
	always_comb begin
		if (cnt_q == VARINT_LAST_IDX) begin
			acc_f  = {acc_q[ACC_W-9:0], data_byte};
			big_f  = big_q | (|acc_q[ACC_W-1:ACC_W-8]);
			done_f = 1'b1;
			cnt_f  = '0;
		end else begin
			acc_f  = {acc_q[ACC_W-8:0], data_byte[6:0]};
			big_f  = big_q | (|acc_q[ACC_W-1:ACC_W-7]);
			done_f = !data_byte[7];
			cnt_f  = done_f ? '0 : cnt_q + CNT_W'(1);
		end
	end

	assign sz = type_size(acc_f, big_f);

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		big_d   = big_q;
		cnt_d   = cnt_q;
		hdr_d   = hdr_q;
		col_d   = col_q;
		body_d  = body_q;
		hoff_d  = hoff_q;
		hsize_d = hsize_q;
		hit_d   = hit_q;
		fail_d  = fail_q;
		pos_d   = (pos_q != SAT_LEN) ? pos_q + LEN_W'(1) : pos_q;

		case (phase_q)
			PH_SIZE: begin
				cnt_d = cnt_f;
				if (done_f) begin
					hdr_d   = sat_len(acc_f, big_f);
					body_d  = sat_len(acc_f, big_f);
					acc_d   = '0;
					big_d   = 1'b0;
					phase_d = PH_TYPES;
				end else begin
					acc_d = acc_f;
					big_d = big_f;
				end
			end
			PH_TYPES: begin
				if (pos_q >= hdr_q) begin
					phase_d = PH_DONE;
				end else begin
					cnt_d = cnt_f;
					if (done_f) begin
						acc_d = '0;
						big_d = 1'b0;
						if (col_q == column_index) begin
							hit_d   = 1'b1;
							fail_d  = !big_f && (acc_f < BLOB_MIN_TYPE);
							hoff_d  = body_q;
							hsize_d = sz;
							phase_d = PH_DONE;
						end else begin
							body_d = sat_len(ACC_W'(body_q) + ACC_W'(sz), 1'b0);
							if (col_q != COL_MAX)
								col_d = col_q + COL_W'(1);
						end
					end else begin
						acc_d = acc_f;
						big_d = big_f;
					end
				end
			end
			PH_DONE: begin
			end
			default: begin
				phase_d = PH_SIZE;
			end
		endcase
	end

	always_comb begin
		summary.past_size   = (phase_d != PH_SIZE);
		summary.hit         = hit_d;
		summary.fail        = fail_d;
		summary.len         = pos_d;
		summary.header_size = hdr_d;
		summary.hit_offset  = hoff_d;
		summary.hit_size    = hsize_d;
	end

	assign push = accept && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			acc_q   <= '0;
			big_q   <= 1'b0;
			cnt_q   <= '0;
			pos_q   <= '0;
			hdr_q   <= '0;
			col_q   <= '0;
			body_q  <= '0;
			hoff_q  <= '0;
			hsize_q <= '0;
			hit_q   <= 1'b0;
			fail_q  <= 1'b0;
		end else if (accept) begin
			if (last) begin
				phase_q <= PH_SIZE;
				acc_q   <= '0;
				big_q   <= 1'b0;
				cnt_q   <= '0;
				pos_q   <= '0;
				hdr_q   <= '0;
				col_q   <= '0;
				body_q  <= '0;
				hoff_q  <= '0;
				hsize_q <= '0;
				hit_q   <= 1'b0;
				fail_q  <= 1'b0;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				big_q   <= big_d;
				cnt_q   <= cnt_d;
				pos_q   <= pos_d;
				hdr_q   <= hdr_d;
				col_q   <= col_d;
				body_q  <= body_d;
				hoff_q  <= hoff_d;
				hsize_q <= hsize_d;
				hit_q   <= hit_d;
				fail_q  <= fail_d;
			end
		end
	end

endmodule

// ===== sv/rcl_queue.sv =====
module rcl_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rcl_pkg::rcl_summary_t wr_data,
	input  logic                  pop,
	output logic                  full,
	output logic                  not_empty,
	output rcl_pkg::rcl_summary_t rd_data
);
	import rcl_pkg::*;

	rcl_summary_t      entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full      = (count_q == (QPTR_W+1)'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

endmodule

// ===== sv/rcl_back.sv =====
module rcl_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  rcl_pkg::rcl_summary_t    q_data,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     found,
	output logic [rcl_pkg::OUT_W-1:0] column_offset,
	output logic [rcl_pkg::OUT_W-1:0] column_size
);
	import rcl_pkg::*;

	logic             out_valid_q;
	logic             found_q;
	logic [OUT_W-1:0] offset_q, size_q;
	logic [LEN_W:0]   end_sum;
	logic             ok;

	assign end_sum = {1'b0, q_data.hit_offset} + {1'b0, q_data.hit_size};
	assign ok = q_data.past_size && q_data.hit && !q_data.fail &&
		(q_data.len <= MAX_LEN) && (q_data.header_size <= q_data.len) &&
		(end_sum <= {1'b0, q_data.len});

	assign q_pop = q_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!out_valid_q || !out_stall)
			out_valid_q <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			found_q  <= ok;
			offset_q <= ok ? OUT_W'(q_data.hit_offset) : '0;
			size_q   <= ok ? OUT_W'(q_data.hit_size) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign column_offset = offset_q;
	assign column_size   = size_q;

endmodule

// ===== sv/record_column_locator.sv =====
// Locates one column body in a streamed database record. Bytes enter one per cycle while
// in_stall is low, on data_byte with last on the final byte; the header (size varint, then one
// serial-type varint per column) is parsed on the fly, and one result transaction per record
// reports found, the body offset from record start and the body size (both zero when not
// found). The result leaves through a two-entry record queue and then an output register,
// and in_stall rises only when that queue is full because results are not being taken.
// column_index (address 0) must be written between records.
module record_column_locator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        found,
	output logic [rcl_pkg::OUT_W-1:0]   column_offset,
	output logic [rcl_pkg::OUT_W-1:0]   column_size,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rcl_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import rcl_pkg::*;

	logic             in_accept;
	logic             push;
	rcl_summary_t     wr_summary, rd_summary;
	logic             q_full, q_valid, q_pop;
	logic [COL_W-1:0] column_index_q;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1] == REG_COLUMN_INDEX);
	assign prdata  = reg_sel ? 32'(column_index_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			column_index_q <= '0;
		else if (psel && penable && pwrite && pready && reg_sel)
			column_index_q <= pwdata[COL_W-1:0];
	end

	assign in_stall  = q_full;
	assign in_accept = in_valid && !in_stall;

	rcl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_accept),
		.data_byte    (data_byte),
		.last         (last),
		.column_index (column_index_q),
		.push         (push),
		.summary      (wr_summary)
	);

	rcl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   (wr_summary),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.rd_data   (rd_summary)
	);

	rcl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_data        (rd_summary),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.found         (found),
		.column_offset (column_offset),
		.column_size   (column_size)
	);

endmodule
